// ===== rtl/input_state_tracker_fnv_hash_macros.svh =====
// assertion helpers shared by the checker
`ifndef INPUT_STATE_TRACKER_FNV_HASH_MACROS_SVH
`define INPUT_STATE_TRACKER_FNV_HASH_MACROS_SVH

// same-cycle implication, disabled during reset
`define ISTFNV_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// next-cycle implication, disabled during reset
`define ISTFNV_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

// ===== rtl/istfnv_pkg.sv =====
`default_nettype none

package istfnv_pkg;

   typedef struct packed {
      logic [15:0]        schema_version;
      logic [63:0]        tick;
      logic signed [15:0] bank_sample;
      logic signed [15:0] pitch_sample;
      logic               other_axis_invalid;
      logic               fire_held;
      logic               fire_pressed;
      logic               fire_released;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]  error_code;
      logic [63:0] state_hash;
   } rsp_payload_type;

   localparam logic [2:0] ErrOk        = 3'd0;
   localparam logic [2:0] ErrSchema    = 3'd1;
   localparam logic [2:0] ErrTick      = 3'd2;
   localparam logic [2:0] ErrQ15       = 3'd3;
   localparam logic [2:0] ErrOverflow  = 3'd4;

   localparam logic [15:0] SchemaReset  = 16'd1;
   localparam logic [15:0] Q15Invalid   = 16'h8000;
   localparam logic [15:0] RecordVersion = 16'd1;
   localparam logic [31:0] RecordMarker = 32'h5350_4641;

   localparam int RecordBytes = 43;
   localparam int RecordWidth = RecordBytes * 8;
   localparam int CountWidth  = $clog2(RecordBytes);

   localparam logic [63:0] FnvBasis    = 64'hcbf2_9ce4_8422_2325;
   localparam logic [63:0] FnvPrimeLow = 64'h0000_0000_0000_01b3;
   localparam int          FnvPrimeShift = 40;

   // prime is 2^40 + 0x1b3, so the multiply is a shift plus a narrow constant product
   function automatic logic [63:0] fnv_mix(input logic [63:0] h, input logic [7:0] b);
      logic [63:0] x;
      logic [63:0] low;
      x   = h ^ {56'd0, b};
      low = x * FnvPrimeLow;
      return (x << FnvPrimeShift) + low;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/input_state_tracker_fnv_hash.sv =====
// a result shows rsp_valid once all record bytes of its accepted request are hashed
// requests are taken only in idle, after the previous hash is done; the byte-serial
//   fnv-1a loop walks the 43 record bytes, one dependent multiply per cycle
// a pending result in the output register stalls only the final hash write
// reset (synchronous, active high) clears tracked state, sets expected_schema to 1
`default_nettype none

module input_state_tracker_fnv_hash
   import istfnv_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire req_payload_type req_data,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output rsp_payload_type      rsp_data,
   input  wire logic            csr_wr_en,
   input  wire logic [15:0]     csr_wr_data
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_HASH,
      S_DONE
   } state_type;

   state_type             state_ff;
   logic [CountWidth-1:0] count_ff;
   logic [63:0]           hash_ff;
   logic [RecordWidth-1:0] record_ff;
   logic [2:0]            err_ff;
   logic                  rsp_valid_ff;
   rsp_payload_type       rsp_data_ff;
   logic [15:0]           expected_schema_ff;

   logic [15:0] bank_intent_ff,     bank_intent_in;
   logic [15:0] pitch_intent_ff,    pitch_intent_in;
   logic        held_flag_ff,       held_flag_in;
   logic [63:0] press_count_ff,     press_count_in;
   logic [63:0] release_count_ff,   release_count_in;
   logic [63:0] completed_steps_ff, completed_steps_in;
   logic [63:0] last_tick_ff,       last_tick_in;

   logic [2:0]             err_in;
   logic [RecordWidth-1:0] record_in;
   logic [63:0]            hash_mixed;
   logic                   accept;
   logic                   slot_free;
   logic                   last_byte;
   logic                   rsp_load;

   assign req_ready  = (state_ff == S_IDLE);
   assign accept     = req_valid && req_ready;
   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign last_byte  = (count_ff == CountWidth'(RecordBytes - 1));
   assign rsp_load   = slot_free && ((state_ff == S_HASH && last_byte) || state_ff == S_DONE);
   assign hash_mixed = fnv_mix(hash_ff, record_ff[7:0]);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // frame checks in priority order
   always_comb begin
      priority if (req_data.schema_version != expected_schema_ff) begin
         err_in = ErrSchema;
      end else if (completed_steps_ff != 64'd0 && req_data.tick <= last_tick_ff) begin
         err_in = ErrTick;
      end else if (req_data.bank_sample == Q15Invalid || req_data.pitch_sample == Q15Invalid
                   || req_data.other_axis_invalid) begin
         err_in = ErrQ15;
      end else if (&completed_steps_ff || (req_data.fire_pressed && &press_count_ff)
                   || (req_data.fire_released && &release_count_ff)) begin
         err_in = ErrOverflow;
      end else begin
         err_in = ErrOk;
      end
   end

   always_comb begin
      bank_intent_in     = bank_intent_ff;
      pitch_intent_in    = pitch_intent_ff;
      held_flag_in       = held_flag_ff;
      press_count_in     = press_count_ff;
      release_count_in   = release_count_ff;
      completed_steps_in = completed_steps_ff;
      last_tick_in       = last_tick_ff;
      if (err_in == ErrOk) begin
         bank_intent_in     = req_data.bank_sample;
         pitch_intent_in    = req_data.pitch_sample;
         held_flag_in       = req_data.fire_held;
         press_count_in     = press_count_ff + {63'd0, req_data.fire_pressed};
         release_count_in   = release_count_ff + {63'd0, req_data.fire_released};
         completed_steps_in = completed_steps_ff + 64'd1;
         last_tick_in       = req_data.tick;
      end
   end

   // first record byte sits in the low bits
   assign record_in = {last_tick_in, completed_steps_in, release_count_in, press_count_in,
                       7'd0, held_flag_in, pitch_intent_in, bank_intent_in,
                       RecordVersion, RecordMarker};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= S_IDLE;
         count_ff           <= '0;
         rsp_valid_ff       <= 1'b0;
         expected_schema_ff <= SchemaReset;
         bank_intent_ff     <= '0;
         pitch_intent_ff    <= '0;
         held_flag_ff       <= 1'b0;
         press_count_ff     <= '0;
         release_count_ff   <= '0;
         completed_steps_ff <= '0;
         last_tick_ff       <= '0;
      end else begin
         if (csr_wr_en) begin
            expected_schema_ff <= csr_wr_data;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  bank_intent_ff     <= bank_intent_in;
                  pitch_intent_ff    <= pitch_intent_in;
                  held_flag_ff       <= held_flag_in;
                  press_count_ff     <= press_count_in;
                  release_count_ff   <= release_count_in;
                  completed_steps_ff <= completed_steps_in;
                  last_tick_ff       <= last_tick_in;
                  err_ff             <= err_in;
                  record_ff          <= record_in;
                  hash_ff            <= FnvBasis;
                  count_ff           <= '0;
                  state_ff           <= S_HASH;
               end
            end
            S_HASH: begin
               record_ff <= record_ff >> 8;
               if (last_byte) begin
                  if (slot_free) begin
                     rsp_data_ff <= '{error_code: err_ff, state_hash: hash_mixed};
                     state_ff    <= S_IDLE;
                  end else begin
                     hash_ff  <= hash_mixed;
                     state_ff <= S_DONE;
                  end
               end else begin
                  hash_ff  <= hash_mixed;
                  count_ff <= count_ff + CountWidth'(1);
               end
            end
            S_DONE: begin
               // output beat still pending, hold the finished hash
               if (slot_free) begin
                  rsp_data_ff <= '{error_code: err_ff, state_hash: hash_ff};
                  state_ff    <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== rtl/istfnv_checker.sv =====
`include "input_state_tracker_fnv_hash_macros.svh"
`default_nettype none

module istfnv_checker
   import istfnv_pkg::*;
(
   input wire logic            clock,
   input wire logic            reset,
   input wire logic            req_valid,
   input wire logic            req_ready,
   input wire req_payload_type req_data,
   input wire logic            rsp_valid,
   input wire logic            rsp_ready,
   input wire rsp_payload_type rsp_data
);

   logic req_beat;
   logic req_wait;
   logic rsp_wait;

   assign req_beat = req_valid && req_ready;
   assign req_wait = req_valid && !req_ready;
   assign rsp_wait = rsp_valid && !rsp_ready;

   // a waiting request beat keeps its payload
   `ISTFNV_ASSERT_NEXT(a_req_hold, clock, reset, req_wait, req_valid && $stable(req_data))

   // a stalled result beat keeps its payload
   `ISTFNV_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_wait, rsp_valid && $stable(rsp_data))

   // the block is busy hashing right after it takes a beat
   `ISTFNV_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_beat, !req_ready)

   // a result never rises in the cycle right after a request beat
   `ISTFNV_ASSERT_NEXT(a_no_early_rsp, clock, reset, req_beat, !$rose(rsp_valid))

   // reported codes stay within the defined set
   `ISTFNV_ASSERT_IMP(a_code_range, clock, reset, rsp_valid, rsp_data.error_code <= ErrOverflow)

endmodule

bind input_state_tracker_fnv_hash istfnv_checker u_istfnv_checker (.*);

`default_nettype wire
